/* sv/cvm_pkg.sv */
// Shared types, constants and the exp(-2^k) table for the exponentiality statistic unit.
// No dependencies.
package cvm_pkg;

	localparam int CVM_MAX_SAMPLES = 1024;
	localparam int EXP_STEPS       = 20;
	localparam int ND_W            = 24;
	localparam int STAT_W          = 27;
	localparam int U_W             = 16;

	typedef enum logic [4:0] {
		S_LOAD, S_CHECK, S_XF_RD, S_XF_MUL, S_DV_GO, S_DV, S_EX_MUL, S_EX_RND, S_XF_WR,
		S_SO_INIT, S_SO_RD, S_SO_WR, S_N1_GO, S_N1, S_TINIT, S_N2_GO, S_N2,
		S_SU_RD, S_SU_MUL, S_SU_ACC, S_FIN, S_DEGEN
	} cvm_state_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic xf_init;
		logic xf_mul;
		logic dv_init;
		logic dv_step;
		logic ex_mul;
		logic ex_rnd;
		logic xf_wr;
		logic so_init;
		logic so_wr;
		logic nd_init;
		logic nd_sel;
		logic nd_step;
		logic t_init;
		logic su_rd;
		logic su_mul;
		logic su_acc;
		logic out_stat;
		logic out_degen;
	} cvm_cmd_t;

	typedef struct packed {
		logic total_zero;
		logic k_last;
		logic dv_last;
		logic ex_need;
		logic ex_last;
		logic sort_skip;
		logic sort_end;
		logic nd_last;
		logic out_free;
	} cvm_sts_t;

	// round(2^32 * exp(-2^(p-16)))
	function automatic logic [31:0] exp_neg_pow2(input logic [4:0] p);
		logic [31:0] c;
		case (p)
			5'd0:  c = 32'd4294901760;
			5'd1:  c = 32'd4294836226;
			5'd2:  c = 32'd4294705160;
			5'd3:  c = 32'd4294443040;
			5'd4:  c = 32'd4293918848;
			5'd5:  c = 32'd4292870656;
			5'd6:  c = 32'd4290775039;
			5'd7:  c = 32'd4286586875;
			5'd8:  c = 32'd4278222805;
			5'd9:  c = 32'd4261543595;
			5'd10: c = 32'd4228380000;
			5'd11: c = 32'd4162825044;
			5'd12: c = 32'd4034748382;
			5'd13: c = 32'd3790295335;
			5'd14: c = 32'd3344923893;
			5'd15: c = 32'd2605029347;
			5'd16: c = 32'd1580030169;
			5'd17: c = 32'd581260615;
			5'd18: c = 32'd78665070;
			5'd19: c = 32'd1440801;
			default: c = 32'd0;
		endcase
		return c;
	endfunction

endpackage

/* sv/cvm_exponentiality_statistic_unit.sv */
// Cramer-von Mises exponentiality statistic unit: samples stream in one beat per cycle
// (s_tlast closes a set); after the set the unit maps each sample to u = 1 - exp(-x/mean),
// merge-sorts the u values and emits W in Q11.16 on m_tdata, m_tuser set when the sum is
// zero. Per sample after the closing beat the unit reads, multiplies, starts the divider and
// writes back, with the x*n/total divider giving one ratio bit per step and the exp chain a
// multiply step per ratio bit plus a rounding step per set bit after the first; then come
// ceil(log2 n) merge passes (each element read, then written; two read copies per buffer),
// two serial divisions with 24-bit quotients and the sum of squares (read, multiply, add).
// No input is taken from the closing beat until the result is placed in the output register.
// Depends on cvm_pkg, cvm_ctrl, cvm_datapath, cvm_ram.
module cvm_exponentiality_statistic_unit import cvm_pkg::*; #(
	parameter int MAX_SAMPLES = CVM_MAX_SAMPLES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample_value
	input  logic        s_tlast,   // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [26:0] statistic, zero fill above
	output logic        m_tuser    // degenerate
);

	cvm_cmd_t          cmd;
	cvm_sts_t          sts;
	logic [STAT_W-1:0] stat;

	cvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cvm_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.sample   (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.stat     (stat),
		.deg      (m_tuser)
	);

	assign m_tdata = {{(32 - STAT_W){1'b0}}, stat};

endmodule

/* sv/cvm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cvm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/cvm_ctrl.sv */
// Sequencer for the exponentiality statistic unit: load, transform, merge sort, sum.
// Depends on cvm_pkg.
module cvm_ctrl import cvm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic     s_tlast,
	output logic     s_tready,
	input  cvm_sts_t sts,
	output cvm_cmd_t cmd
);

	cvm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD:    if (s_tvalid && s_tlast) state_d = S_CHECK;
			S_CHECK:   state_d = sts.total_zero ? S_DEGEN : S_XF_RD;
			S_XF_RD:   state_d = S_XF_MUL;
			S_XF_MUL:  state_d = S_DV_GO;
			S_DV_GO:   state_d = S_DV;
			S_DV:      if (sts.dv_last) state_d = S_EX_MUL;
			S_EX_MUL: begin
				if (sts.ex_need) state_d = S_EX_RND;
				else if (sts.ex_last) state_d = S_XF_WR;
			end
			S_EX_RND:  state_d = sts.ex_last ? S_XF_WR : S_EX_MUL;
			S_XF_WR:   state_d = sts.k_last ? S_SO_INIT : S_XF_RD;
			S_SO_INIT: state_d = sts.sort_skip ? S_N1_GO : S_SO_RD;
			S_SO_RD:   state_d = S_SO_WR;
			S_SO_WR:   state_d = sts.sort_end ? S_N1_GO : S_SO_RD;
			S_N1_GO:   state_d = S_N1;
			S_N1:      if (sts.nd_last) state_d = S_TINIT;
			S_TINIT:   state_d = S_N2_GO;
			S_N2_GO:   state_d = S_N2;
			S_N2:      if (sts.nd_last) state_d = S_SU_RD;
			S_SU_RD:   state_d = S_SU_MUL;
			S_SU_MUL:  state_d = S_SU_ACC;
			S_SU_ACC:  state_d = sts.k_last ? S_FIN : S_SU_RD;
			S_FIN:     if (sts.out_free) state_d = S_LOAD;
			S_DEGEN:   if (sts.out_free) state_d = S_LOAD;
			default:   state_d = S_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_CHECK:   cmd.xf_init = 1'b1;
			S_XF_MUL:  cmd.xf_mul  = 1'b1;
			S_DV_GO:   cmd.dv_init = 1'b1;
			S_DV:      cmd.dv_step = 1'b1;
			S_EX_MUL:  cmd.ex_mul  = 1'b1;
			S_EX_RND:  cmd.ex_rnd  = 1'b1;
			S_XF_WR:   cmd.xf_wr   = 1'b1;
			S_SO_INIT: cmd.so_init = 1'b1;
			S_SO_WR:   cmd.so_wr   = 1'b1;
			S_N1_GO:   cmd.nd_init = 1'b1;
			S_N1:      cmd.nd_step = 1'b1;
			S_TINIT:   cmd.t_init  = 1'b1;
			S_N2_GO: begin
				cmd.nd_init = 1'b1;
				cmd.nd_sel  = 1'b1;
			end
			S_N2:      cmd.nd_step = 1'b1;
			S_SU_RD:   cmd.su_rd   = 1'b1;
			S_SU_MUL:  cmd.su_mul  = 1'b1;
			S_SU_ACC:  cmd.su_acc  = 1'b1;
			S_FIN: begin
				cmd.out_stat = sts.out_free;
				cmd.clr      = sts.out_free;
			end
			S_DEGEN: begin
				cmd.out_degen = sts.out_free;
				cmd.clr       = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

/* sv/cvm_datapath.sv */
// Datapath: sample store, ratio divider, exp multiplier, merge-sort buffers, sum of squares.
// Depends on cvm_pkg and cvm_ram.
module cvm_datapath import cvm_pkg::*; #(
	parameter int MAX_SAMPLES = CVM_MAX_SAMPLES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cvm_cmd_t            cmd,
	output cvm_sts_t            sts,
	input  logic [31:0]         sample,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [STAT_W-1:0]   stat,
	output logic                deg
);

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int TW  = 32 + AW;
	localparam int PW  = 32 + CW;
	localparam int XW  = PW + 20;
	localparam int DVW = CW + 4;
	localparam int QW  = ND_W + 1;
	localparam int ACW = 50 + CW;
	localparam int IW  = CW + 3;

	// load
	logic [CW-1:0] count_q;
	logic [TW-1:0] total_q;
	logic          full;
	logic [31:0]   smp_rd;

	assign full = (count_q >= CW'(MAX_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.clr) begin
			count_q <= '0;
			total_q <= '0;
		end else if (cmd.load && !full) begin
			count_q <= count_q + 1'b1;
			total_q <= total_q + TW'(sample);
		end
	end

	logic [CW-1:0] k_q;

	cvm_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_smp (
		.clk   (clk),
		.we    (cmd.load && !full),
		.waddr (count_q[AW-1:0]),
		.wdata (sample),
		.raddr (k_q[AW-1:0]),
		.rdata (smp_rd)
	);

	// ratio r = x*n/total in Q.16, exp(-r) in Q0.32
	logic [PW-1:0] prod_q;
	logic [XW-1:0] rem_q, dsh_q;
	logic [19:0]   r_q;
	logic          big_q, one_q;
	logic [4:0]    dcnt_q, p_q;
	logic [31:0]   eacc_q;
	logic [63:0]   mprod_q;
	logic          dv_ge, r_bit;
	logic [63:0]   mrnd;
	logic [32:0]   e33;
	logic [33:0]   usum;
	logic [U_W-1:0] u_val;

	assign dv_ge = (rem_q >= dsh_q);
	assign r_bit = r_q[p_q] && !big_q;
	assign mrnd  = mprod_q + 64'h8000_0000;
	assign e33   = big_q ? 33'd0 : (one_q ? {1'b1, 32'd0} : {1'b0, eacc_q});
	assign usum  = 34'({1'b1, 32'd0}) - 34'(e33) + 34'h8000;
	assign u_val = (usum[33:16] > 18'd65535) ? 16'hFFFF : usum[31:16];

	always_ff @(posedge clk) begin
		if (cmd.xf_mul) begin
			prod_q <= PW'(smp_rd) * PW'(count_q);
		end
		if (cmd.dv_init) begin
			rem_q  <= XW'({prod_q, 16'd0});
			dsh_q  <= XW'({total_q, 19'd0});
			big_q  <= XW'({prod_q, 16'd0}) >= XW'({total_q, 20'd0});
			r_q    <= '0;
			eacc_q <= '0;
		end else if (cmd.dv_step) begin
			if (dv_ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			r_q   <= {r_q[18:0], dv_ge};
		end
		if (cmd.ex_mul && r_bit) begin
			if (one_q) begin
				eacc_q <= exp_neg_pow2(p_q);
			end else begin
				mprod_q <= eacc_q * exp_neg_pow2(p_q);
			end
		end
		if (cmd.ex_rnd) begin
			eacc_q <= mrnd[63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			p_q    <= '0;
			one_q  <= 1'b1;
		end else if (cmd.dv_init) begin
			dcnt_q <= '0;
			p_q    <= '0;
			one_q  <= 1'b1;
		end else begin
			if (cmd.dv_step) dcnt_q <= dcnt_q + 1'b1;
			if (cmd.ex_mul && r_bit && one_q) one_q <= 1'b0;
			if ((cmd.ex_mul && !sts.ex_need) || cmd.ex_rnd) p_q <= p_q + 1'b1;
		end
	end

	// merge sort over ping-pong buffers, two read copies each
	logic                sel_q;
	logic [CW:0]         w_q;
	logic [CW-1:0]       i_q, j_q, mid_q, hi_q, o_q;
	logic [U_W-1:0]      a0_rd, a1_rd, b0_rd, b1_rd, src0, src1;
	logic                take_a, run_done, pass_end;
	logic [CW-1:0]       i_nx, j_nx, lo_n, mid_n, hi_n, ra0;
	logic [CW:0]         w_n;
	logic [IW-1:0]       mid_sum, hi_sum;
	logic                we_a, we_b;
	logic [CW-1:0]       wa;
	logic [U_W-1:0]      wd;

	assign src0     = sel_q ? b0_rd : a0_rd;
	assign src1     = sel_q ? b1_rd : a1_rd;
	assign take_a   = (i_q < mid_q) && ((j_q >= hi_q) || (src0 <= src1));
	assign i_nx     = i_q + CW'(take_a);
	assign j_nx     = j_q + CW'(!take_a);
	assign run_done = (i_nx == mid_q) && (j_nx == hi_q);
	assign pass_end = run_done && (hi_q == count_q);

	always_comb begin
		if (cmd.so_init) begin
			lo_n = '0;
			w_n  = (CW + 1)'(1);
		end else if (pass_end) begin
			lo_n = '0;
			w_n  = w_q << 1;
		end else begin
			lo_n = hi_q;
			w_n  = w_q;
		end
		mid_sum = IW'(lo_n) + IW'(w_n);
		hi_sum  = IW'(lo_n) + (IW'(w_n) << 1);
		mid_n   = (mid_sum > IW'(count_q)) ? count_q : mid_sum[CW-1:0];
		hi_n    = (hi_sum > IW'(count_q)) ? count_q : hi_sum[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			w_q   <= '0;
			i_q   <= '0;
			j_q   <= '0;
			mid_q <= '0;
			hi_q  <= '0;
			o_q   <= '0;
		end else if (cmd.so_init || (cmd.so_wr && run_done)) begin
			i_q   <= lo_n;
			j_q   <= mid_n;
			mid_q <= mid_n;
			hi_q  <= hi_n;
			w_q   <= w_n;
			if (cmd.so_init) begin
				sel_q <= 1'b0;
				o_q   <= '0;
			end else if (pass_end) begin
				sel_q <= !sel_q;
				o_q   <= '0;
			end else begin
				o_q <= o_q + 1'b1;
			end
		end else if (cmd.so_wr) begin
			i_q <= i_nx;
			j_q <= j_nx;
			o_q <= o_q + 1'b1;
		end
	end

	assign we_a = cmd.xf_wr || (cmd.so_wr && sel_q);
	assign we_b = cmd.so_wr && !sel_q;
	assign wa   = cmd.xf_wr ? k_q : o_q;
	assign wd   = cmd.xf_wr ? u_val : (take_a ? src0 : src1);
	assign ra0  = cmd.su_rd ? k_q : i_q;

	cvm_ram #(.WIDTH(U_W), .DEPTH(MAX_SAMPLES)) u_buf_a0 (
		.clk(clk), .we(we_a), .waddr(wa[AW-1:0]), .wdata(wd),
		.raddr(ra0[AW-1:0]), .rdata(a0_rd)
	);
	cvm_ram #(.WIDTH(U_W), .DEPTH(MAX_SAMPLES)) u_buf_a1 (
		.clk(clk), .we(we_a), .waddr(wa[AW-1:0]), .wdata(wd),
		.raddr(j_q[AW-1:0]), .rdata(a1_rd)
	);
	cvm_ram #(.WIDTH(U_W), .DEPTH(MAX_SAMPLES)) u_buf_b0 (
		.clk(clk), .we(we_b), .waddr(wa[AW-1:0]), .wdata(wd),
		.raddr(ra0[AW-1:0]), .rdata(b0_rd)
	);
	cvm_ram #(.WIDTH(U_W), .DEPTH(MAX_SAMPLES)) u_buf_b1 (
		.clk(clk), .we(we_b), .waddr(wa[AW-1:0]), .wdata(wd),
		.raddr(j_q[AW-1:0]), .rdata(b1_rd)
	);

	// serial divider: 2^23 / n, then (65536 + 6n) / (12n)
	logic [ND_W-1:0] dd_q, nq_q;
	logic [DVW-1:0]  dv_q, nr_q;
	logic [4:0]      ncnt_q;
	logic [DVW:0]    nsh;
	logic            nge;

	assign nsh = {nr_q, dd_q[ND_W-1]};
	assign nge = (nsh >= {1'b0, dv_q});

	always_ff @(posedge clk) begin
		if (cmd.nd_init) begin
			dd_q <= cmd.nd_sel ? ND_W'(32'd65536 + (32'(count_q) << 2) + (32'(count_q) << 1))
			                   : ND_W'(1 << 23);
			dv_q <= cmd.nd_sel ? DVW'((DVW'(count_q) << 3) + (DVW'(count_q) << 2))
			                   : DVW'(count_q);
			nr_q <= '0;
			nq_q <= '0;
		end else if (cmd.nd_step) begin
			nr_q <= nge ? nsh[DVW-1:0] - dv_q : nsh[DVW-1:0];
			nq_q <= {nq_q[ND_W-2:0], nge};
			dd_q <= dd_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncnt_q <= '0;
		end else if (cmd.nd_init) begin
			ncnt_q <= '0;
		end else if (cmd.nd_step) begin
			ncnt_q <= ncnt_q + 1'b1;
		end
	end

	// targets t_i = round((2i-1) 2^23 / n) kept as quotient and remainder
	logic [QW-1:0]  tq_q, q24_q, ud, dabs;
	logic [CW-1:0]  trem_q, r24_q, r23, half;
	logic [CW:0]    s1, r2, s3;
	logic           ge1, ge2, ge3;
	logic [2*QW-1:0] dsq_q;
	logic [ACW-1:0] acc_q, wsum;
	logic [ACW:0]   arnd;

	assign r23  = nr_q[CW-1:0];
	assign half = count_q >> 1;
	assign s1   = {1'b0, half} + {1'b0, r23};
	assign ge1  = (s1 >= {1'b0, count_q});
	assign r2   = {r23, 1'b0};
	assign ge2  = (r2 >= {1'b0, count_q});
	assign s3   = {1'b0, trem_q} + {1'b0, r24_q};
	assign ge3  = (s3 >= {1'b0, count_q});
	assign ud   = QW'({src0, 8'd0});
	assign dabs = (ud > tq_q) ? ud - tq_q : tq_q - ud;

	always_ff @(posedge clk) begin
		if (cmd.t_init) begin
			tq_q   <= QW'(nq_q) + QW'(ge1);
			trem_q <= ge1 ? CW'(s1 - {1'b0, count_q}) : s1[CW-1:0];
			q24_q  <= QW'({nq_q, 1'b0}) + QW'(ge2);
			r24_q  <= ge2 ? CW'(r2 - {1'b0, count_q}) : r2[CW-1:0];
			acc_q  <= '0;
		end else begin
			if (cmd.su_mul) begin
				dsq_q  <= dabs * dabs;
				tq_q   <= tq_q + q24_q + QW'(ge3);
				trem_q <= ge3 ? CW'(s3 - {1'b0, count_q}) : s3[CW-1:0];
			end
			if (cmd.su_acc) begin
				acc_q <= acc_q + ACW'(dsq_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.xf_init || cmd.t_init) begin
			k_q <= '0;
		end else if (cmd.xf_wr || cmd.su_acc) begin
			k_q <= k_q + 1'b1;
		end
	end

	assign arnd = {1'b0, acc_q} + (ACW + 1)'(32'h8000_0000);
	assign wsum = ACW'(arnd[ACW:32]) + ACW'(nq_q);

	// output beat
	logic [STAT_W-1:0] stat_q;
	logic              deg_q, ovalid_q;

	always_ff @(posedge clk) begin
		if (cmd.out_stat) begin
			stat_q <= (wsum > ACW'({STAT_W{1'b1}})) ? {STAT_W{1'b1}} : wsum[STAT_W-1:0];
			deg_q  <= 1'b0;
		end else if (cmd.out_degen) begin
			stat_q <= '0;
			deg_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_stat || cmd.out_degen) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign m_tvalid = ovalid_q;
	assign stat     = stat_q;
	assign deg      = deg_q;

	assign sts.total_zero = (total_q == '0);
	assign sts.k_last     = (k_q == count_q - 1'b1);
	assign sts.dv_last    = (dcnt_q == 5'(EXP_STEPS - 1));
	assign sts.ex_need    = r_bit && !one_q;
	assign sts.ex_last    = (p_q == 5'(EXP_STEPS - 1));
	assign sts.sort_skip  = (count_q == CW'(1));
	assign sts.sort_end   = cmd.so_wr && pass_end && ((IW'(w_q) << 1) >= IW'(count_q));
	assign sts.nd_last    = (ncnt_q == 5'(ND_W - 1));
	assign sts.out_free   = !ovalid_q || m_tready;

endmodule

/* sv/cvm_checker.sv */
// Port-level checks for the exponentiality statistic unit, bound to the top level.
// Depends on cvm_exponentiality_statistic_unit.
module cvm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("degenerate beat with nonzero statistic");

	a_keep_loading: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("stopped loading inside a set");

	a_close_set: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("accepted a beat right after the closing beat");

endmodule

bind cvm_exponentiality_statistic_unit cvm_checker u_cvm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/tb_cvm_exponentiality_statistic_unit.sv */
// Testbench for cvm_exponentiality_statistic_unit: streams sample sets in bursts, predicts
// each statistic with a local fixed-point model and checks every output beat in order.
// Depends on cvm_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_cvm_exponentiality_statistic_unit;
	import cvm_pkg::*;

	localparam int LIMIT = 3000000;

	typedef struct {
		logic [31:0] value;
		logic        last;
		bit          drain;
	} sample_beat_t;

	typedef struct {
		logic [26:0] stat;
		logic        degen;
	} stat_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;

	cvm_exponentiality_statistic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	sample_beat_t   beat_q[$];
	stat_result_t   stat_q[$];
	logic [31:0]    set_samples[$];
	logic [63:0]    set_total;
	int             errors;
	int             results_seen;
	int             cycles;
	bit             s_fire;
	int             burst_left;
	int             gap_left;
	int             hold_left;
	bit             hold_done;

	logic [31:0] exp_step[20] = '{
		32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
		32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
		32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
		32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
		32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
	};

	function automatic logic [15:0] uniform_of(logic [31:0] x, logic [63:0] n, logic [63:0] tot);
		logic [63:0] prod, q, rem, r, e, u;
		prod = {32'd0, x} * n;
		q    = prod / tot;
		rem  = prod % tot;
		r    = (q << 16) | ((rem << 16) / tot);
		e    = 64'd1 << 32;
		if ((r >> 20) != 0)
			e = 0;
		else
			for (int p = 0; p < 20; p++)
				if (r[p])
					e = (e * {32'd0, exp_step[p]} + (64'd1 << 31)) >> 32;
		u = (((64'd1 << 32) - e) + (64'd1 << 15)) >> 16;
		return (u > 64'd65535) ? 16'hFFFF : u[15:0];
	endfunction

	function automatic stat_result_t cvm_statistic(logic [31:0] xs[$], logic [63:0] tot);
		stat_result_t res;
		int unsigned  us[$];
		logic [63:0]  n, acc, t, u24, d, w;
		n = 64'(xs.size());
		res.stat  = '0;
		res.degen = 1'b1;
		if (tot == 0 || n == 0)
			return res;
		foreach (xs[k])
			us.insert(us.size(), 32'(uniform_of(xs[k], n, tot)));
		us.sort();
		acc = 0;
		foreach (us[k]) begin
			t   = (((2 * (k + 1) - 1) << 23) + n / 2) / n;
			u24 = us[k] << 8;
			d   = (u24 > t) ? u24 - t : t - u24;
			acc += d * d;
		end
		w = (acc + (64'd1 << 31)) >> 32;
		w += (65536 + 6 * n) / (12 * n);
		res.stat  = (w > 64'h7FFFFFF) ? 27'h7FFFFFF : w[26:0];
		res.degen = 1'b0;
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
		errors++;
	endtask

	task automatic add_beat(logic [31:0] v, logic l);
		sample_beat_t b;
		b.value = v;
		b.last  = l;
		b.drain = 0;
		beat_q.insert(beat_q.size(), b);
	endtask

	task automatic add_drain();
		sample_beat_t b;
		b.value = '0;
		b.last  = 0;
		b.drain = 1;
		beat_q.insert(beat_q.size(), b);
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 255);
			2: return 32'h10000 + $urandom_range(0, 65535);
			3: return ($urandom_range(0, 1)) ? 32'hFFFFFFFF : 32'h0;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		int n, total_items;
		logic [31:0] v;
		arst_n = 0;
		add_beat(32'h10000, 1);
		add_beat(32'h0, 1);
		add_beat(32'h0, 0); add_beat(32'h0, 0); add_beat(32'h0, 1);
		add_beat(32'hFFFFFFFF, 0); add_beat(32'hFFFFFFFF, 1);
		add_beat(32'h30000, 0); add_beat(32'h30000, 0); add_beat(32'h30000, 1);
		for (int k = 0; k < 14; k++)
			add_beat(32'h0, 0);
		add_beat(32'hFFFFFFFF, 1);
		add_drain();
		total_items = 25;
		while (total_items < 450) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
			for (int k = 0; k < n; k++) begin
				v = ($urandom_range(0, 19) == 0) ? 32'h0 : rand_sample();
				add_beat(v, k == n - 1);
			end
			total_items += n;
			if (total_items > 200 && total_items - n <= 200)
				add_drain();
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (beat_q.size() == 0 && !s_tvalid);
		wait (stat_q.size() == 0);
		repeat (3000) @(posedge clk);
		if (errors == 0 && stat_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	always @(negedge clk or negedge arst_n) begin
		bit          nv;
		logic [31:0] nd;
		logic        nl;
		if (!arst_n) begin
			s_tvalid   <= 0;
			s_tdata    <= '0;
			s_tlast    <= 0;
			burst_left <= 4;
			gap_left   <= 0;
		end else if (!(s_tvalid && !s_fire)) begin
			nv = 0;
			nd = s_tdata;
			nl = s_tlast;
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (beat_q.size() > 0 && beat_q[0].drain) begin
				if (stat_q.size() == 0)
					void'(beat_q.pop_front());
			end else if (beat_q.size() > 0) begin
				nv = 1;
				nd = beat_q[0].value;
				nl = beat_q[0].last;
				void'(beat_q.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
			s_tvalid <= nv;
			s_tdata  <= nd;
			s_tlast  <= nl;
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 0;
		end else if (!hold_done && results_seen == 6) begin
			hold_done <= 1;
			hold_left <= 20000;
			m_tready  <= 0;
		end else if ((cycles / 200) % 3 == 0) begin
			m_tready <= 1;
		end else begin
			m_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		stat_result_t want;
		if (!arst_n) begin
			s_fire       <= 0;
			errors       <= 0;
			results_seen <= 0;
			cycles       <= 0;
			set_total    = 0;
			set_samples.delete();
		end else begin
			cycles <= cycles + 1;
			if (cycles > LIMIT) begin
				$display("FAIL");
				$finish;
			end
			s_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				if (set_samples.size() < CVM_MAX_SAMPLES) begin
					set_samples.insert(set_samples.size(), s_tdata);
					set_total += s_tdata;
				end
				if (s_tlast) begin
					stat_q.insert(stat_q.size(), cvm_statistic(set_samples, set_total));
					set_samples.delete();
					set_total = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (stat_q.size() == 0) begin
					report("unexpected beat", m_tdata, 32'h0);
				end else begin
					want = stat_q.pop_front();
					if (m_tdata !== {5'd0, want.stat})
						report("statistic", m_tdata, {5'd0, want.stat});
					if (m_tuser !== want.degen)
						report("degenerate", 32'(m_tuser), 32'(want.degen));
				end
			end
		end
	end

endmodule
